[rtl/tcce_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcce_pkg: shared types and constants for the text console character engine
// Cell layout, control characters, opcodes and the sequencer state encoding.
// ----------------------------------------------------------------------------
package tcce_pkg;

	// One screen cell: attribute in the high byte, character in the low byte
	localparam int unsigned CELL_W = 16;
	localparam int unsigned CHAR_W = 8;

	localparam logic [3:0] COLOR_BLACK = 4'd0;
	localparam logic [3:0] COLOR_WHITE = 4'd15;

	localparam logic [CHAR_W-1:0] TEXT_ATTR  = {COLOR_BLACK, COLOR_WHITE};
	localparam logic [CELL_W-1:0] BLANK_CELL = {TEXT_ATTR, 8'h20};

	// Tab stops every eight columns
	localparam int unsigned TAB_STOP = 8;

	// Control characters
	localparam logic [CHAR_W-1:0] CH_BS = 8'd8;
	localparam logic [CHAR_W-1:0] CH_HT = 8'd9;
	localparam logic [CHAR_W-1:0] CH_LF = 8'd10;
	localparam logic [CHAR_W-1:0] CH_CR = 8'd13;

	typedef enum logic {
		OP_PUT  = 1'b0,
		OP_READ = 1'b1
	} opcode_t;

	// Sequencer states, one-hot
	typedef enum logic [5:0] {
		ST_CLEAR  = 6'b000001,
		ST_IDLE   = 6'b000010,
		ST_EXEC   = 6'b000100,
		ST_SCROLL = 6'b001000,
		ST_RDWAIT = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

endpackage
`default_nettype wire

[rtl/tcce_screen_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcce_screen_ram: screen cell storage
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tcce_screen_ram #(
	parameter int unsigned DEPTH  = 2000,
	parameter int unsigned ADDR_W = 11
) (
	input  wire logic                             clk,
	input  wire logic                             wr_en,
	input  wire logic [ADDR_W-1:0]                wr_addr,
	input  wire logic [tcce_pkg::CELL_W-1:0]      wr_data,
	input  wire logic                             rd_en,
	input  wire logic [ADDR_W-1:0]                rd_addr,
	output logic      [tcce_pkg::CELL_W-1:0]      rd_data
);

	logic [tcce_pkg::CELL_W-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port, registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

[rtl/text_console_char_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_char_engine: text screen with cursor and scrolling
// Puts characters at the cursor, handles control codes, scrolls and reads
// back single cells. Screen contents live in one on-chip memory.
// ----------------------------------------------------------------------------
// After reset the block sweeps the whole screen memory to white-on-black
// spaces, one cell per cycle, and holds in_stall high until done. Items are
// then handled one at a time: a put passes through execute and done, a read
// on the screen through execute, read wait and done (one memory read with a
// registered data path). A put that finds a scroll pending first blanks one
// screen row at one cell per cycle and then passes through execute again;
// rows are never copied, since the screen is addressed through a rotating
// top-row pointer. A new item is taken while the previous result still waits
// on the output register.
// ----------------------------------------------------------------------------
module text_console_char_engine #(
	parameter int unsigned COLUMNS = 80,
	parameter int unsigned ROWS    = 25
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        opcode,
	input  wire logic [7:0]  char_code,
	input  wire logic [4:0]  read_row,
	input  wire logic [6:0]  read_col,
	// Output channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      cell_value,
	output logic [6:0]       cursor_col,
	output logic [4:0]       cursor_row
);

	localparam int unsigned DEPTH  = ROWS * COLUMNS;
	localparam int unsigned ADDR_W = $clog2(DEPTH);
	localparam int unsigned ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int unsigned LINE_W = $clog2(ROWS + 1);
	localparam int unsigned COL_W  = $clog2(COLUMNS);

	localparam logic [ADDR_W-1:0] COLS_A   = ADDR_W'(COLUMNS);
	localparam logic [ADDR_W-1:0] LAST_A   = ADDR_W'(DEPTH - 1);
	localparam logic [ROW_W:0]    ROWS_X   = (ROW_W + 1)'(ROWS);
	localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(ROWS - 1);
	localparam logic [LINE_W-1:0] LAST_LN  = LINE_W'(ROWS - 1);
	localparam logic [LINE_W-1:0] ROWS_LN  = LINE_W'(ROWS);
	localparam logic [COL_W-1:0]  LAST_COL = COL_W'(COLUMNS - 1);
	localparam logic [COL_W:0]    COLS_X   = (COL_W + 1)'(COLUMNS);
	localparam logic [COL_W:0]    TAB_ADD  = (COL_W + 1)'(tcce_pkg::TAB_STOP);
	localparam logic [COL_W:0]    TAB_MASK = ~((COL_W + 1)'(tcce_pkg::TAB_STOP - 1));

	// Logical row plus top pointer, folded back into the screen
	function automatic logic [ROW_W-1:0] wrap_row(input logic [ROW_W:0] s);
		return (s >= ROWS_X) ? ROW_W'(s - ROWS_X) : ROW_W'(s);
	endfunction

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
	                                                input logic [COL_W-1:0] c);
		return ADDR_W'(ADDR_W'(r) * COLS_A) + ADDR_W'(c);
	endfunction

	tcce_pkg::state_t            state_q;
	logic [ADDR_W-1:0]           clr_q;
	logic [COL_W-1:0]            swp_q;
	logic [ROW_W-1:0]            top_q;
	logic [COL_W-1:0]            col_q;
	logic [LINE_W-1:0]           line_q;

	// Latched item
	tcce_pkg::opcode_t           op_q;
	logic [7:0]                  char_q;
	logic [4:0]                  rrow_q;
	logic [6:0]                  rcol_q;
	logic [15:0]                 cell_q;

	// Output register
	logic                        out_valid_q;
	logic [15:0]                 cell_value_q;
	logic [6:0]                  cursor_col_q;
	logic [4:0]                  cursor_row_q;

	// Memory port
	logic                        wr_en;
	logic [ADDR_W-1:0]           wr_addr;
	logic [15:0]                 wr_data;
	logic                        rd_en;
	logic [ADDR_W-1:0]           rd_addr;
	logic [15:0]                 rd_data;

	logic                        rd_in_range;
	logic                        scroll_pend;
	logic                        is_print;
	logic [ROW_W-1:0]            cur_phys;
	logic [ROW_W-1:0]            rd_phys;
	logic [COL_W:0]              col_inc;
	logic [COL_W:0]              col_tab;
	logic [COL_W-1:0]            col_n;
	logic [LINE_W-1:0]           line_n;
	logic                        swp_last;
	logic                        out_free;

	assign in_stall    = (state_q != tcce_pkg::ST_IDLE);
	assign out_free    = !out_valid_q || !out_stall;
	assign rd_in_range = (32'(rrow_q) < ROWS) && (32'(rcol_q) < COLUMNS);
	assign scroll_pend = (line_q >= ROWS_LN);
	assign is_print    = (char_q != tcce_pkg::CH_BS) && (char_q != tcce_pkg::CH_HT) &&
	                     (char_q != tcce_pkg::CH_LF) && (char_q != tcce_pkg::CH_CR);
	assign cur_phys    = wrap_row((ROW_W + 1)'(line_q) + {1'b0, top_q});
	assign rd_phys     = wrap_row((ROW_W + 1)'(rrow_q) + {1'b0, top_q});
	assign swp_last    = (swp_q == LAST_COL);

	// Cursor update for a put
	always_comb begin
		col_inc = {1'b0, col_q} + (COL_W + 1)'(1);
		col_tab = ({1'b0, col_q} + TAB_ADD) & TAB_MASK;
		col_n   = col_q;
		line_n  = line_q;
		unique case (char_q)
			tcce_pkg::CH_BS: begin
				if (col_q != '0) begin
					col_n = col_q - COL_W'(1);
				end
			end
			tcce_pkg::CH_HT: begin
				if (col_tab >= COLS_X) begin
					col_n  = '0;
					line_n = line_q + LINE_W'(1);
				end else begin
					col_n = COL_W'(col_tab);
				end
			end
			tcce_pkg::CH_LF: begin
				col_n  = '0;
				line_n = line_q + LINE_W'(1);
			end
			tcce_pkg::CH_CR: begin
				col_n = '0;
			end
			default: begin
				if (col_inc >= COLS_X) begin
					col_n  = '0;
					line_n = line_q + LINE_W'(1);
				end else begin
					col_n = COL_W'(col_inc);
				end
			end
		endcase
	end

	// Memory strobes per state
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = clr_q;
		wr_data = tcce_pkg::BLANK_CELL;
		rd_en   = 1'b0;
		rd_addr = cell_addr(rd_phys, COL_W'(rcol_q));
		unique case (state_q)
			tcce_pkg::ST_CLEAR: begin
				wr_en = 1'b1;
			end
			tcce_pkg::ST_SCROLL: begin
				wr_en   = 1'b1;
				wr_addr = cell_addr(top_q, swp_q);
			end
			tcce_pkg::ST_EXEC: begin
				if (op_q == tcce_pkg::OP_READ) begin
					rd_en = rd_in_range;
				end else if (!scroll_pend && is_print) begin
					wr_en   = 1'b1;
					wr_addr = cell_addr(cur_phys, col_q);
					wr_data = {tcce_pkg::TEXT_ATTR, char_q};
				end
			end
			default: begin
			end
		endcase
	end

	tcce_screen_ram #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Sequencer and cursor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcce_pkg::ST_CLEAR;
			clr_q   <= '0;
			swp_q   <= '0;
			top_q   <= '0;
			col_q   <= '0;
			line_q  <= '0;
		end else begin
			unique case (state_q)
				tcce_pkg::ST_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == LAST_A) begin
						state_q <= tcce_pkg::ST_IDLE;
					end
				end
				tcce_pkg::ST_IDLE: begin
					if (in_valid) begin
						state_q <= tcce_pkg::ST_EXEC;
					end
				end
				tcce_pkg::ST_EXEC: begin
					if (op_q == tcce_pkg::OP_READ) begin
						state_q <= rd_in_range ? tcce_pkg::ST_RDWAIT : tcce_pkg::ST_DONE;
					end else if (scroll_pend) begin
						swp_q   <= '0;
						state_q <= tcce_pkg::ST_SCROLL;
					end else begin
						col_q   <= col_n;
						line_q  <= line_n;
						state_q <= tcce_pkg::ST_DONE;
					end
				end
				tcce_pkg::ST_SCROLL: begin
					swp_q <= swp_q + COL_W'(1);
					if (swp_last) begin
						top_q   <= (top_q == LAST_ROW) ? '0 : top_q + ROW_W'(1);
						line_q  <= LAST_LN;
						state_q <= tcce_pkg::ST_EXEC;
					end
				end
				tcce_pkg::ST_RDWAIT: begin
					state_q <= tcce_pkg::ST_DONE;
				end
				tcce_pkg::ST_DONE: begin
					if (out_free) begin
						state_q <= tcce_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= tcce_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Item capture and read data
	always_ff @(posedge clk) begin
		if (state_q == tcce_pkg::ST_IDLE && in_valid) begin
			op_q   <= tcce_pkg::opcode_t'(opcode);
			char_q <= char_code;
			rrow_q <= read_row;
			rcol_q <= read_col;
			cell_q <= '0;
		end else if (state_q == tcce_pkg::ST_RDWAIT) begin
			cell_q <= rd_data;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == tcce_pkg::ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tcce_pkg::ST_DONE && out_free) begin
			cell_value_q <= cell_q;
			cursor_col_q <= 7'(col_q);
			cursor_row_q <= 5'(line_q);
		end
	end

	assign out_valid  = out_valid_q;
	assign cell_value = cell_value_q;
	assign cursor_col = cursor_col_q;
	assign cursor_row = cursor_row_q;

	// Checks
	a_top_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(top_q) < ROWS)
		else $error("top row pointer out of range");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(col_q) < COLUMNS)
		else $error("cursor column out of range");

	a_line_range: assert property (@(posedge clk) disable iff (!arst_n)
		line_q <= ROWS_LN)
		else $error("cursor line beyond scroll pending");

	a_scroll_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tcce_pkg::ST_SCROLL) && swp_last
		|=> (state_q == tcce_pkg::ST_EXEC) && (line_q == LAST_LN))
		else $error("scroll did not return to execute on last row");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tcce_pkg::ST_IDLE) || (state_q == tcce_pkg::ST_DONE)
		|-> !wr_en && !rd_en)
		else $error("memory access outside an active state");

endmodule
`default_nettype wire

[test/text_console_char_engine_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_char_engine_tb: self-checking bench for the text console engine
// Walks a short table of puts and reads, with hand-typed results where they
// are obvious (reset contents, screen edges, cells outside the screen). It then
// streams random text, control codes and reads. Each beat is checked against
// its typed result or a shadow screen and cursor kept here. The sender works in
// bursts with gaps, and the receiver stalls on a mode pattern of its own.
// ----------------------------------------------------------------------------
module text_console_char_engine_tb;

	localparam int unsigned COLUMNS      = 80;
	localparam int unsigned ROWS         = 25;
	localparam int          RANDOM_ITEMS = 700;
	localparam int          N_SCRIPT     = 25;

	// One output beat, in port order
	typedef struct packed {
		logic [15:0] cell_val;
		logic [6:0]  col;
		logic [4:0]  row;
	} console_beat_t;

	typedef struct {
		tcce_pkg::opcode_t op;
		logic [7:0]  ch;
		logic [4:0]  rrow;
		logic [6:0]  rcol;
		int          reps;
		bit          known;
		logic [15:0] cell_val;
		logic [6:0]  ccol;
		logic [4:0]  crow;
	} script_row_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic        opcode    = 1'b0;
	logic [7:0]  char_code = '0;
	logic [4:0]  read_row  = '0;
	logic [6:0]  read_col  = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] cell_value;
	logic [6:0]  cursor_col;
	logic [4:0]  cursor_row;

	// Shadow screen and cursor
	logic [15:0]   screen_image [ROWS*COLUMNS];
	int            cur_col;
	int            cur_line;
	console_beat_t awaited_beats [$];

	int fail_count;
	int n_puts, n_reads, n_scrolls, n_outside, n_tab_wraps, n_row_wraps;
	int burst_left;
	int stall_mode, stall_left;

	// Directed table: hand-typed results where known = 1
	script_row_t script [N_SCRIPT] = '{
		'{tcce_pkg::OP_READ, 8'h00,  0,   0,  1, 1, tcce_pkg::BLANK_CELL, 0,  0},
		'{tcce_pkg::OP_READ, 8'h00, 24,  79,  1, 1, tcce_pkg::BLANK_CELL, 0,  0},
		'{tcce_pkg::OP_READ, 8'h00, 31, 127,  1, 1, 16'h0000,   0,  0},
		'{tcce_pkg::OP_READ, 8'h00, 25,   0,  1, 1, 16'h0000,   0,  0},
		'{tcce_pkg::OP_READ, 8'h00,  0,  80,  1, 1, 16'h0000,   0,  0},
		'{tcce_pkg::OP_PUT,  tcce_pkg::CH_BS,  0,   0,  1, 1, 16'h0000,   0,  0},
		'{tcce_pkg::OP_PUT,  8'h41,  0,   0,  1, 1, 16'h0000,   1,  0},
		'{tcce_pkg::OP_PUT,  8'hFF, 31, 127,  1, 1, 16'h0000,   2,  0},
		'{tcce_pkg::OP_PUT,  8'h00,  0,   0,  1, 1, 16'h0000,   3,  0},
		'{tcce_pkg::OP_READ, 8'h00,  0,   0,  1, 1, 16'h0F41,   3,  0},
		'{tcce_pkg::OP_READ, 8'hFF,  0,   1,  1, 1, 16'h0FFF,   3,  0},
		'{tcce_pkg::OP_READ, 8'h00,  0,   2,  1, 1, 16'h0F00,   3,  0},
		'{tcce_pkg::OP_PUT,  tcce_pkg::CH_BS,  0,   0,  1, 1, 16'h0000,   2,  0},
		'{tcce_pkg::OP_PUT,  tcce_pkg::CH_HT,  0,   0,  1, 1, 16'h0000,   8,  0},
		'{tcce_pkg::OP_PUT,  tcce_pkg::CH_CR,  0,   0,  1, 1, 16'h0000,   0,  0},
		// tab stops to the row end, the last one wraps
		'{tcce_pkg::OP_PUT,  tcce_pkg::CH_HT,  0,   0, 10, 0, 16'h0000,   0,  0},
		// down to the last row
		'{tcce_pkg::OP_PUT,  tcce_pkg::CH_LF,  0,   0, 23, 0, 16'h0000,   0,  0},
		'{tcce_pkg::OP_PUT,  8'h80,  0,   0,  1, 1, 16'h0000,   1, 24},
		// newline on the last row leaves a scroll pending
		'{tcce_pkg::OP_PUT,  tcce_pkg::CH_LF,  0,   0,  1, 1, 16'h0000,   0, 25},
		'{tcce_pkg::OP_READ, 8'h00, 24,   0,  1, 1, 16'h0F80,   0, 25},
		'{tcce_pkg::OP_PUT,  8'h5A,  0,   0,  1, 1, 16'h0000,   1, 24},
		'{tcce_pkg::OP_READ, 8'h00, 23,   0,  1, 1, 16'h0F80,   1, 24},
		'{tcce_pkg::OP_READ, 8'h00, 24,   0,  1, 1, 16'h0F5A,   1, 24},
		'{tcce_pkg::OP_PUT,  tcce_pkg::CH_HT,  0,   0,  1, 0, 16'h0000,   0,  0},
		'{tcce_pkg::OP_READ, 8'h00,  0,   0,  1, 0, 16'h0000,   0,  0}
	};

	text_console_char_engine #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.char_code (char_code),
		.read_row  (read_row),
		.read_col  (read_col),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cell_value(cell_value),
		.cursor_col(cursor_col),
		.cursor_row(cursor_row)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow console: apply one item, return the beat it should produce
	task automatic console_step(input tcce_pkg::opcode_t op, input logic [7:0] ch,
			input logic [4:0] rr, input logic [6:0] rc, output console_beat_t res);
		int next_stop;
		res.cell_val = '0;
		if (op == tcce_pkg::OP_PUT) begin
			n_puts++;
			// pending scroll: shift rows up, blank the bottom one
			if (cur_line >= ROWS) begin
				for (int i = 0; i < (ROWS-1)*COLUMNS; i++)
					screen_image[i] = screen_image[i+COLUMNS];
				for (int i = 0; i < COLUMNS; i++)
					screen_image[(ROWS-1)*COLUMNS+i] = tcce_pkg::BLANK_CELL;
				cur_line = ROWS - 1;
				n_scrolls++;
			end
			case (ch)
				tcce_pkg::CH_BS: begin
					if (cur_col > 0)
						cur_col--;
				end
				tcce_pkg::CH_HT: begin
					next_stop = (cur_col + tcce_pkg::TAB_STOP) & ~(tcce_pkg::TAB_STOP - 1);
					if (next_stop >= COLUMNS) begin
						cur_col = 0;
						cur_line++;
						n_tab_wraps++;
					end else begin
						cur_col = next_stop;
					end
				end
				tcce_pkg::CH_LF: begin
					cur_col = 0;
					cur_line++;
				end
				tcce_pkg::CH_CR: begin
					cur_col = 0;
				end
				default: begin
					screen_image[cur_line*COLUMNS+cur_col] = {tcce_pkg::TEXT_ATTR, ch};
					cur_col++;
					if (cur_col >= COLUMNS) begin
						cur_col = 0;
						cur_line++;
						n_row_wraps++;
					end
				end
			endcase
		end else begin
			n_reads++;
			if (rr < ROWS && rc < COLUMNS)
				res.cell_val = screen_image[rr*COLUMNS+rc];
			else
				n_outside++;
		end
		res.col = 7'(cur_col);
		res.row = 5'(cur_line);
	endtask

	// Drive one beat, wait for acceptance, queue its result, then pace
	task automatic send_item(input tcce_pkg::opcode_t op, input logic [7:0] ch,
			input logic [4:0] rr, input logic [6:0] rc,
			input bit known, input console_beat_t typed);
		console_beat_t predicted;
		in_valid  <= 1'b1;
		opcode    <= op;
		char_code <= ch;
		read_row  <= rr;
		read_col  <= rc;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		console_step(op, ch, rr, rc, predicted);
		awaited_beats.push_back(known ? typed : predicted);
		burst_left--;
		if (burst_left <= 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(1, 16);
		end
	endtask

	// Hold off until every queued result has come out
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaited_beats.size() != 0)
			@(posedge clk);
	endtask

	// Output check and receiver stall pattern
	always @(posedge clk) begin
		console_beat_t want;
		if (out_valid === 1'b1 && out_stall === 1'b0) begin
			if (awaited_beats.size() == 0) begin
				$display("%0t: unexpected beat: cell %h col %0d row %0d",
					$time, cell_value, cursor_col, cursor_row);
				fail_count++;
			end else begin
				want = awaited_beats.pop_front();
				if (cell_value !== want.cell_val) begin
					$display("%0t: cell_value mismatch: expected %h, got %h",
						$time, want.cell_val, cell_value);
					fail_count++;
				end
				if (cursor_col !== want.col) begin
					$display("%0t: cursor_col mismatch: expected %0d, got %0d",
						$time, want.col, cursor_col);
					fail_count++;
				end
				if (cursor_row !== want.row) begin
					$display("%0t: cursor_row mismatch: expected %0d, got %0d",
						$time, want.row, cursor_row);
					fail_count++;
				end
			end
		end
		// modes: no stall, coin flip, runs of eight
		if (stall_left <= 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_left = $urandom_range(20, 200);
		end
		stall_left--;
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= 1'($urandom_range(0, 1));
			default: out_stall <= (stall_left & 8) != 0;
		endcase
	end

	// Reset, directed table, random traffic, wrap-up
	initial begin
		int          pick;
		int          run_len;
		int          random_left;
		logic [4:0]  near_row;
		console_beat_t typed;

		for (int i = 0; i < ROWS*COLUMNS; i++)
			screen_image[i] = tcce_pkg::BLANK_CELL;
		cur_col    = 0;
		cur_line   = 0;
		burst_left = 1;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			typed = {script[i].cell_val, script[i].ccol, script[i].crow};
			repeat (script[i].reps)
				send_item(script[i].op, script[i].ch, script[i].rrow, script[i].rcol,
					script[i].known, typed);
		end
		drain_results();

		// Random text: printable runs, random bytes and control codes; reads near the cursor, on screen and off it
		random_left = RANDOM_ITEMS;
		while (random_left > 0) begin
			pick = $urandom_range(0, 99);
			near_row = cur_line < ROWS ? 5'(cur_line) : 5'(ROWS - 1);
			if (pick < 3) begin
				// long line, to wrap at the row end
				run_len = $urandom_range(60, 100);
				repeat (run_len)
					send_item(tcce_pkg::OP_PUT, 8'($urandom_range(32, 126)), 5'($urandom),
						7'($urandom), 1'b0, '0);
				random_left -= run_len;
			end else begin
				if (pick < 45)
					send_item(tcce_pkg::OP_PUT, 8'($urandom_range(0, 255)), 5'($urandom),
						7'($urandom), 1'b0, '0);
				else if (pick < 53)
					send_item(tcce_pkg::OP_PUT, tcce_pkg::CH_LF, 5'($urandom),
						7'($urandom), 1'b0, '0);
				else if (pick < 57)
					send_item(tcce_pkg::OP_PUT, tcce_pkg::CH_CR, 5'($urandom),
						7'($urandom), 1'b0, '0);
				else if (pick < 62)
					send_item(tcce_pkg::OP_PUT, tcce_pkg::CH_BS, 5'($urandom),
						7'($urandom), 1'b0, '0);
				else if (pick < 69)
					send_item(tcce_pkg::OP_PUT, tcce_pkg::CH_HT, 5'($urandom),
						7'($urandom), 1'b0, '0);
				else if (pick < 80)
					send_item(tcce_pkg::OP_READ, 8'($urandom), near_row,
						7'($urandom_range(0, COLUMNS - 1)), 1'b0, '0);
				else if (pick < 90)
					send_item(tcce_pkg::OP_READ, 8'($urandom),
						5'($urandom_range(0, ROWS - 1)),
						7'($urandom_range(0, COLUMNS - 1)), 1'b0, '0);
				else
					send_item(tcce_pkg::OP_READ, 8'($urandom), 5'($urandom),
						7'($urandom), 1'b0, '0);
				random_left--;
			end
			if ($urandom_range(0, 149) == 0)
				drain_results();
		end

		drain_results();
		repeat (50) @(posedge clk);

		$display("Covered %0d puts and %0d reads (%0d off-screen), with %0d scrolls,",
			n_puts, n_reads, n_outside, n_scrolls);
		$display("%0d tab wraps and %0d line wraps at the row end.",
			n_tab_wraps, n_row_wraps);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Watchdog
	initial begin
		#6_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

[sim.f]
rtl/tcce_pkg.sv
rtl/tcce_screen_ram.sv
rtl/text_console_char_engine.sv
test/text_console_char_engine_tb.sv
